### hdl/qwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qwr_pkg
// Shared types and constants for the linear queue with reverse unit.
// ----------------------------------------------------------------------------
package qwr_pkg;

	localparam int DEPTH  = 1024;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_REV  = 2'd3
	} qwr_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} qwr_status_t;

	typedef struct packed {
		qwr_op_t                  req_type;
		logic signed [WORD_W-1:0] push_value;
	} qwr_req_t;

	typedef struct packed {
		qwr_status_t              status;
		logic signed [WORD_W-1:0] head_value;
		logic [CNT_W-1:0]         item_count;
		logic                     is_empty;
	} qwr_res_t;

	// Slot memory access: one write port, two read ports.
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr0;
		logic [IDX_W-1:0]  raddr1;
	} qwr_ram_req_t;

endpackage
`default_nettype wire

### hdl/linear_queue_with_reverse_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_queue_with_reverse_unit
// Linear array queue of signed 32-bit words with in-place reversal.
// ----------------------------------------------------------------------------
// Each accepted item is one request (enqueue, dequeue, peek, reverse) and
// yields exactly one result item: status, head word (-1 when empty), word
// count and empty flag, all describing the queue after the request. The
// queue is linear: the tail never wraps, so enqueue reports overflow once
// the tail sits in the last slot even if slots ahead of the head are free;
// both indices return to zero when the queue runs empty. Words live in a
// 1024 x 32 synchronous RAM with one write and two read ports; the current
// head word is cached in a register, so enqueue and peek never wait on a
// RAM read; a dequeue that moves the head and a reverse of two or more
// words do. Enqueue and peek can stream back to back while the output is
// not stalled; a dequeue that leaves words behind passes through S_DEQ for
// the RAM read of the new head; reverse runs S_SWP_LO then S_SWP_HI once
// per swap, as both swapped words go through the single RAM write port.
// The swap sequence never reads a slot in the same cycle it is written, so
// no forwarding is needed. The RAM needs no clearing after reset. A finished
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module linear_queue_with_reverse_unit
	import qwr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire qwr_req_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output qwr_res_t      out_data
);

	qwr_ram_req_t      ram_req;
	logic [WORD_W-1:0] rd0;
	logic [WORD_W-1:0] rd1;
	logic              res_valid;
	qwr_res_t          res;
	logic              out_free;
	logic              out_valid_q;
	qwr_res_t          out_data_q;

	// Output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	qwr_ram u_ram (
		.clk (clk),
		.req (ram_req),
		.rd0 (rd0),
		.rd1 (rd1)
	);

	qwr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req       (in_data),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.ram_req   (ram_req),
		.rd0       (rd0),
		.rd1       (rd1)
	);

	// Result holding register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

### hdl/qwr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qwr_ram
// Slot store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module qwr_ram
	import qwr_pkg::*;
(
	input  wire logic              clk,
	input  wire qwr_ram_req_t      req,
	output logic [WORD_W-1:0]      rd0,
	output logic [WORD_W-1:0]      rd1
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd0 <= mem[req.raddr0];
		rd1 <= mem[req.raddr1];
	end

endmodule
`default_nettype wire

### hdl/qwr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qwr_ctrl
// Request sequencer: head/tail indices, cached head word, swap loop.
// ----------------------------------------------------------------------------
module qwr_ctrl
	import qwr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire qwr_req_t          req,
	input  wire logic              out_free,
	output logic                   res_valid,
	output qwr_res_t               res,
	output qwr_ram_req_t           ram_req,
	input  wire logic [WORD_W-1:0] rd0,
	input  wire logic [WORD_W-1:0] rd1
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DEQ    = 5'b00010,
		S_SWP_LO = 5'b00100,
		S_SWP_HI = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [IDX_W-1:0]  tail_q, tail_d;
	logic              empty_q, empty_d;
	logic [IDX_W-1:0]  lo_q, lo_d;
	logic [IDX_W-1:0]  hi_q, hi_d;
	qwr_status_t       status_q, status_d;
	logic [WORD_W-1:0] head_word_q, head_word_d;
	logic [WORD_W-1:0] tmp_q, tmp_d;
	logic              take;

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		empty_d     = empty_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		status_d    = status_q;
		head_word_d = head_word_q;
		tmp_d       = tmp_q;
		ram_req     = '0;
		res_valid   = 1'b0;
		in_ready    = 1'b0;

		take = (state_q == S_IDLE) || ((state_q == S_RESP) && out_free);

		unique case (state_q)
			S_IDLE: begin
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_DEQ: begin
				head_word_d = rd0;
				state_d     = S_RESP;
			end
			S_SWP_LO: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = lo_q;
				ram_req.wdata = rd1;
				tmp_d         = rd0;
				if (lo_q == head_q) begin
					head_word_d = rd1;
				end
				state_d = S_SWP_HI;
			end
			S_SWP_HI: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = hi_q;
				ram_req.wdata = tmp_q;
				lo_d          = lo_q + IDX_W'(1);
				hi_d          = hi_q - IDX_W'(1);
				if ((lo_q + IDX_W'(1)) < (hi_q - IDX_W'(1))) begin
					ram_req.raddr0 = lo_q + IDX_W'(1);
					ram_req.raddr1 = hi_q - IDX_W'(1);
					state_d        = S_SWP_LO;
				end else begin
					state_d = S_RESP;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (take) begin
			in_ready = 1'b1;
			if (in_valid) begin
				status_d = ST_OK;
				state_d  = S_RESP;
				unique case (req.req_type)
					OP_ENQ: begin
						if (empty_q) begin
							ram_req.we    = 1'b1;
							ram_req.waddr = '0;
							ram_req.wdata = req.push_value;
							head_d        = '0;
							tail_d        = '0;
							empty_d       = 1'b0;
							head_word_d   = req.push_value;
						end else if (tail_q >= IDX_LAST) begin
							status_d = ST_OVERFLOW;
						end else begin
							ram_req.we    = 1'b1;
							ram_req.waddr = tail_q + IDX_W'(1);
							ram_req.wdata = req.push_value;
							tail_d        = tail_q + IDX_W'(1);
						end
					end
					OP_DEQ: begin
						if (empty_q) begin
							status_d = ST_EMPTY;
						end else if (head_q >= tail_q) begin
							head_d  = '0;
							tail_d  = '0;
							empty_d = 1'b1;
						end else begin
							head_d         = head_q + IDX_W'(1);
							ram_req.raddr0 = head_q + IDX_W'(1);
							state_d        = S_DEQ;
						end
					end
					OP_PEEK: begin
						if (empty_q) begin
							status_d = ST_EMPTY;
						end
					end
					OP_REV: begin
						if (empty_q) begin
							status_d = ST_EMPTY;
						end else if (head_q < tail_q) begin
							ram_req.raddr0 = head_q;
							ram_req.raddr1 = tail_q;
							lo_d           = head_q;
							hi_d           = tail_q;
							state_d        = S_SWP_LO;
						end
					end
					default: state_d = S_RESP;
				endcase
			end
		end
	end

	always_comb begin
		res.status     = status_q;
		res.is_empty   = empty_q;
		res.head_value = empty_q ? '1 : head_word_q;
		res.item_count = empty_q ? '0
			: CNT_W'(tail_q) - CNT_W'(head_q) + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			empty_q  <= 1'b1;
			lo_q     <= '0;
			hi_q     <= '0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			empty_q  <= empty_d;
			lo_q     <= lo_d;
			hi_q     <= hi_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		head_word_q <= head_word_d;
		tmp_q       <= tmp_d;
	end

endmodule
`default_nettype wire
